@@ rtl/core/tip_pkg.sv @@
// Shared package for the saturating text integer parser.
// Holds character codes, register indexes, the parse phase type, digit decode
// and the status structs passed between the parser submodules. No dependencies.
`default_nettype none

package tip_pkg;

	localparam int VALUE_WIDTH_DEF = 32;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int MAX_W       = 31;
	localparam int MIN_W       = 32;
	localparam int CHAR_W      = 8;
	localparam int RESULT_W    = 32;
	localparam int DIGIT_W     = 6;

	localparam logic [CFG_INDEX_W-1:0] REG_MAX_VALUE   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_VALUE   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_HEX_DEFAULT = 2'd2;

	localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_0       = 8'h30;
	localparam logic [CHAR_W-1:0] CH_9       = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;
	localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;

	localparam logic [DIGIT_W-1:0] DIGIT_TEN = 6'h0A;

	typedef enum logic [4:0] {
		PH_START  = 5'b00001,
		PH_BASE   = 5'b00010,
		PH_ZERO   = 5'b00100,
		PH_DIGITS = 5'b01000,
		PH_DONE   = 5'b10000
	} phase_t;

	typedef struct packed {
		logic is_digit;
		logic cap_hit;
	} dig_stat_t;

	typedef struct packed {
		logic valid;
		logic neg;
	} fin_ctrl_t;

	// Value of a character taken as a base-36 digit; bytes between the
	// digit groups count zero.
	function automatic logic [DIGIT_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] d;
		d = '0;
		if (c <= CH_9) begin
			d = c - CH_0;
		end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
			d = c - CH_UPPER_A + CHAR_W'(DIGIT_TEN);
		end else if (c >= CH_LOWER_A) begin
			d = c - CH_LOWER_A + CHAR_W'(DIGIT_TEN);
		end
		return d[DIGIT_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/tip_digit.sv @@
// Digit step of the parser: decodes one character in the selected base,
// forms accumulator times base plus digit and applies the magnitude cap.
// Depends on tip_pkg.
`default_nettype none

module tip_digit #(
	parameter int VALUE_WIDTH = tip_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic [tip_pkg::CHAR_W-1:0] char_code,
	input  wire logic                       hex_sel,
	input  wire logic [VALUE_WIDTH-1:0]     acc,
	input  wire logic [tip_pkg::MAX_W-1:0]  max_value,
	output tip_pkg::dig_stat_t              stat,
	output logic      [VALUE_WIDTH-1:0]     acc_next
);
	import tip_pkg::*;

	localparam int NEXT_W = (VALUE_WIDTH + 6 > 64) ? 64 : VALUE_WIDTH + 6;
	localparam int CMP_W  = (NEXT_W > MAX_W) ? NEXT_W : MAX_W;

	logic [NEXT_W-1:0] acc_x;
	logic [NEXT_W-1:0] prod;
	logic [NEXT_W-1:0] next_val;

	always_comb begin
		acc_x = NEXT_W'(acc);
		if (hex_sel) begin
			stat.is_digit = (char_code >= CH_0) && (char_code <= CH_LOWER_Z);
			prod = acc_x << 4;
		end else begin
			stat.is_digit = char_code inside {[CH_0:CH_9]};
			prod = (acc_x << 3) + (acc_x << 1);
		end
		next_val = prod + NEXT_W'(digit_value(char_code));
		stat.cap_hit = (max_value != '0) && (CMP_W'(next_val) > CMP_W'(max_value));
		acc_next = stat.cap_hit ? VALUE_WIDTH'(max_value) : next_val[VALUE_WIDTH-1:0];
	end

endmodule

`default_nettype wire

@@ rtl/core/tip_parse.sv @@
// Input register and per-character parse state: sign, base choice, prefix
// handling and the digit accumulator. Hands the final value to the finish stage.
// Depends on tip_pkg and tip_digit.
`default_nettype none

module tip_parse #(
	parameter int VALUE_WIDTH = tip_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [tip_pkg::CHAR_W-1:0] char_code,
	input  wire logic                       is_last,
	input  wire logic                       hex_default,
	input  wire logic [tip_pkg::MAX_W-1:0]  max_value,
	input  wire logic                       fin_ready,
	output tip_pkg::fin_ctrl_t              fin,
	output logic      [VALUE_WIDTH-1:0]     fin_acc
);
	import tip_pkg::*;

	logic                   valid_s1;
	logic [CHAR_W-1:0]      char_s1;
	logic                   last_s1;

	phase_t                 phase_q;
	logic                   neg_q;
	logic                   hex_q;
	logic [VALUE_WIDTH-1:0] acc_q;

	phase_t                 phase_d;
	logic                   neg_d;
	logic                   hex_d;
	logic [VALUE_WIDTH-1:0] acc_d;

	logic                   proceed;
	logic                   take;
	logic                   base_choice;
	logic                   use_digit;
	logic                   hex_sel;
	dig_stat_t              dig;
	logic [VALUE_WIDTH-1:0] dig_acc;

	assign proceed  = !last_s1 || fin_ready;
	assign take     = valid_s1 && proceed;
	assign in_ready = !valid_s1 || proceed;

	tip_digit #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_digit (
		.char_code(char_s1),
		.hex_sel  (hex_sel),
		.acc      (acc_q),
		.max_value(max_value),
		.stat     (dig),
		.acc_next (dig_acc)
	);

	always_comb begin
		phase_d     = phase_q;
		neg_d       = neg_q;
		hex_d       = hex_q;
		acc_d       = acc_q;
		base_choice = 1'b0;
		use_digit   = 1'b0;
		hex_sel     = hex_q;
		case (phase_q)
			PH_START: begin
				if (char_s1 == CH_MINUS) begin
					neg_d   = 1'b1;
					phase_d = PH_BASE;
				end else begin
					base_choice = 1'b1;
				end
			end
			PH_BASE: begin
				base_choice = 1'b1;
			end
			PH_ZERO: begin
				if (char_s1 == CH_LOWER_X) begin
					hex_d   = 1'b1;
					phase_d = PH_DIGITS;
				end else begin
					hex_sel   = hex_default;
					hex_d     = hex_default;
					use_digit = 1'b1;
				end
			end
			PH_DIGITS: begin
				use_digit = 1'b1;
			end
			PH_DONE: begin
				phase_d = PH_DONE;
			end
			default: begin
				phase_d = PH_DONE;
			end
		endcase
		if (base_choice) begin
			if (char_s1 == CH_0) begin
				phase_d = PH_ZERO;
			end else begin
				hex_sel   = (char_s1 == CH_UPPER_A) || (char_s1 == CH_LOWER_A) || hex_default;
				hex_d     = hex_sel;
				use_digit = 1'b1;
			end
		end
		if (use_digit) begin
			if (!dig.is_digit) begin
				phase_d = PH_DONE;
			end else begin
				acc_d   = dig_acc;
				phase_d = dig.cap_hit ? PH_DONE : PH_DIGITS;
			end
		end
	end

	assign fin.valid = valid_s1 && last_s1 && fin_ready;
	assign fin.neg   = neg_d;
	assign fin_acc   = acc_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_code;
			last_s1 <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			neg_q   <= 1'b0;
			hex_q   <= 1'b0;
			acc_q   <= '0;
		end else if (take) begin
			if (last_s1) begin
				phase_q <= PH_START;
				neg_q   <= 1'b0;
				hex_q   <= 1'b0;
				acc_q   <= '0;
			end else begin
				phase_q <= phase_d;
				neg_q   <= neg_d;
				hex_q   <= hex_d;
				acc_q   <= acc_d;
			end
		end
	end

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(take && last_s1) |=> (phase_q == PH_START && acc_q == '0 && !neg_q && !hex_q))
		else $error("parse state not cleared after the last character");

	a_done_holds_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(take && !last_s1 && phase_q == PH_DONE) |=> ($stable(acc_q) && phase_q == PH_DONE))
		else $error("accumulator changed after parsing ended");

endmodule

`default_nettype wire

@@ rtl/core/tip_finish.sv @@
// Finish stage: applies the lower limit and the sign to the final accumulator
// and holds the result in the output register until taken.
// Depends on tip_pkg.
`default_nettype none

module tip_finish #(
	parameter int VALUE_WIDTH = tip_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  tip_pkg::fin_ctrl_t                fin,
	input  wire logic [VALUE_WIDTH-1:0]       fin_acc,
	output logic                              fin_ready,
	input  wire logic [tip_pkg::MIN_W-1:0]    min_value,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic      [tip_pkg::RESULT_W-1:0] parsed_value
);
	import tip_pkg::*;

	localparam int FW = (VALUE_WIDTH > MIN_W + 1) ? VALUE_WIDTH : MIN_W + 1;

	logic                   valid_s2;
	logic                   neg_s2;
	logic [VALUE_WIDTH-1:0] acc_s2;

	logic                   out_valid_q;
	logic [RESULT_W-1:0]    out_data_q;
	logic                   out_free;
	logic                   advance;

	logic signed [FW-1:0]   t_val;
	logic signed [FW-1:0]   min_x;
	logic signed [FW-1:0]   min_mag;
	logic signed [FW-1:0]   t_sel;
	logic signed [FW-1:0]   res;
	logic                   neg_sel;

	assign out_free  = !out_valid_q || out_ready;
	assign advance   = valid_s2 && out_free;
	assign fin_ready = !valid_s2 || out_free;

	always_comb begin
		t_val   = FW'($signed(acc_s2));
		min_x   = FW'($signed(min_value));
		min_mag = -min_x;
		t_sel   = t_val;
		neg_sel = neg_s2;
		if (min_value[MIN_W-1]) begin
			if (neg_s2 && (min_mag < t_val)) begin
				t_sel = min_mag;
			end
		end else if ((t_val < min_x) || neg_s2) begin
			t_sel   = min_x;
			neg_sel = 1'b0;
		end
		res = neg_sel ? -t_sel : t_sel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fin.valid) begin
			valid_s2 <= 1'b1;
		end else if (advance) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin.valid) begin
			neg_s2 <= fin.neg;
			acc_s2 <= fin_acc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= res[RESULT_W-1:0];
		end
	end

	assign out_valid    = out_valid_q;
	assign parsed_value = out_data_q;

	a_stall_keeps_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready && valid_s2) |=> valid_s2)
		else $error("pending result dropped while the output was stalled");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !fin_ready) |-> !fin.valid)
		else $error("finish stage loaded while still full");

endmodule

`default_nettype wire

@@ rtl/core/text_integer_parser_saturating.sv @@
// Saturating text-to-integer parser, top level: configuration registers and
// the parse and finish stages. Depends on tip_pkg, tip_parse and tip_finish.
// Throughput: one character per cycle, unless a last character waits for the
// finish stage; the digit step sits between the input register and the parse
// state registers. The finish and output registers lie before m_tvalid, which
// comes later while m_tready holds the output. Reset returns the parser to the
// start of a string and clears the accumulator and the registers to zero.
`default_nettype none

module text_integer_parser_saturating #(
	parameter int VALUE_WIDTH = tip_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [tip_pkg::CHAR_W-1:0]      s_tdata,   // [7:0] char_code
	input  wire logic                            s_tlast,   // is_last
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	output logic      [tip_pkg::RESULT_W-1:0]    m_tdata,   // [31:0] parsed_value
	input  wire logic                            cfg_wr_en,
	input  wire logic [tip_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [tip_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import tip_pkg::*;

	logic [MAX_W-1:0]       max_value_q;
	logic [MIN_W-1:0]       min_value_q;
	logic                   hex_default_q;

	fin_ctrl_t              fin;
	logic [VALUE_WIDTH-1:0] fin_acc;
	logic                   fin_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_value_q   <= '0;
			min_value_q   <= '0;
			hex_default_q <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_MAX_VALUE:   max_value_q   <= cfg_data[MAX_W-1:0];
				REG_MIN_VALUE:   min_value_q   <= cfg_data[MIN_W-1:0];
				REG_HEX_DEFAULT: hex_default_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	tip_parse #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.char_code  (s_tdata),
		.is_last    (s_tlast),
		.hex_default(hex_default_q),
		.max_value  (max_value_q),
		.fin_ready  (fin_ready),
		.fin        (fin),
		.fin_acc    (fin_acc)
	);

	tip_finish #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_finish (
		.clk         (clk),
		.arst_n      (arst_n),
		.fin         (fin),
		.fin_acc     (fin_acc),
		.fin_ready   (fin_ready),
		.min_value   (min_value_q),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.parsed_value(m_tdata)
	);

endmodule

`default_nettype wire

@@ dv/tb_text_integer_parser_saturating.sv @@
// Self-checking testbench for text_integer_parser_saturating: streams character
// strings, predicts each parsed, capped and clamped value, and compares results.
// Depends on tip_pkg and the text_integer_parser_saturating RTL.

module tb_text_integer_parser_saturating;
	import tip_pkg::*;

	localparam int HALF_PERIOD = 4;
	localparam int RESET_CYCLES = 9;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_OPS = 100;
	localparam int PHASE_CHARS = 125;
	localparam int HEX_RADIX = 16;
	localparam int DEC_RADIX = 10;
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

	typedef enum logic [1:0] {OP_CHAR, OP_CFG, OP_HOLD} plan_kind_t;

	typedef struct {
		plan_kind_t kind;
		logic [CHAR_W-1:0] code;
		logic is_last;
		logic [CFG_INDEX_W-1:0] idx;
		logic [CFG_DATA_W-1:0] data;
	} plan_op_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [CHAR_W-1:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [RESULT_W-1:0] m_tdata;
	logic cfg_wr_en = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	plan_op_t char_plan[$];
	logic [RESULT_W-1:0] due_values[$];

	int errors = 0;
	int cycles = 0;
	int chars_sent = 0;
	int values_checked = 0;
	int cfg_writes = 0;

	// Idle control for both sides; idle_on and calm are shared.
	logic idle_on = 1'b0;
	logic calm = 1'b0;
	int idle_span = 0;
	int gap_left = 0;
	int stall_left = 0;
	int quiet = 0;

	logic nxt_valid, nxt_last, nxt_wr, nxt_ready;
	logic [CHAR_W-1:0] nxt_data;
	logic [CFG_INDEX_W-1:0] nxt_index;
	logic [CFG_DATA_W-1:0] nxt_cfg;

	// Predictor state and its copy of the registers.
	phase_t ph;
	logic neg_seen;
	logic hex_on;
	logic [31:0] acc;
	logic [MAX_W-1:0] cap;
	logic signed [MIN_W-1:0] min_lim;
	logic hexdef_r;

	text_integer_parser_saturating dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	task automatic clear_parser();
		ph = PH_START;
		neg_seen = 1'b0;
		hex_on = 1'b0;
		acc = '0;
	endtask

	task automatic take_digit(input logic [CHAR_W-1:0] c);
		logic [63:0] nxt;
		logic [5:0] v;
		logic [4:0] base;
		if (hex_on) begin
			if (c < CH_0 || c > CH_LOWER_Z) begin
				ph = PH_DONE;
				return;
			end
			if (c <= CH_9)
				v = 6'(c - CH_0);
			else if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
				v = 6'(c - CH_UPPER_A) + DIGIT_TEN;
			else if (c >= CH_LOWER_A)
				v = 6'(c - CH_LOWER_A) + DIGIT_TEN;
			else
				v = '0;
			base = 5'(HEX_RADIX);
		end else begin
			if (c < CH_0 || c > CH_9) begin
				ph = PH_DONE;
				return;
			end
			v = 6'(c - CH_0);
			base = 5'(DEC_RADIX);
		end
		nxt = 64'(acc) * 64'(base) + 64'(v);
		if (cap == '0 || nxt <= 64'(cap)) begin
			acc = nxt[31:0];
			ph = PH_DIGITS;
		end else begin
			acc = 32'(cap);
			ph = PH_DONE;
		end
	endtask

	task automatic choose_base(input logic [CHAR_W-1:0] c);
		if (c == CH_0) begin
			ph = PH_ZERO;
			return;
		end
		hex_on = (c == CH_UPPER_A || c == CH_LOWER_A || hexdef_r);
		take_digit(c);
	endtask

	function automatic logic [RESULT_W-1:0] clamp_result();
		logic signed [63:0] t;
		logic signed [63:0] lim;
		logic n;
		t = $signed(acc);
		lim = min_lim;
		n = neg_seen;
		// A negative limit bounds only the magnitude of negative results.
		if (lim < 0) begin
			if (n && t > -lim)
				t = -lim;
		end else if (t < lim || n) begin
			t = lim;
			n = 1'b0;
		end
		if (n)
			t = -t;
		return t[RESULT_W-1:0];
	endfunction

	task automatic step_parser(input logic [CHAR_W-1:0] c, input logic end_of_text);
		case (ph)
		PH_START: begin
			if (c == CH_MINUS) begin
				neg_seen = 1'b1;
				ph = PH_BASE;
			end else begin
				choose_base(c);
			end
		end
		PH_BASE: choose_base(c);
		PH_ZERO: begin
			if (c == CH_LOWER_X) begin
				hex_on = 1'b1;
				ph = PH_DIGITS;
			end else begin
				hex_on = hexdef_r;
				acc = '0;
				take_digit(c);
			end
		end
		PH_DIGITS: take_digit(c);
		default: ph = PH_DONE;
		endcase
		if (end_of_text) begin
			due_values.push_back(clamp_result());
			clear_parser();
		end
	endtask

	task automatic plan(input plan_kind_t k, input logic [CHAR_W-1:0] c, input logic l,
			input logic [CFG_INDEX_W-1:0] i, input logic [CFG_DATA_W-1:0] d);
		plan_op_t op;
		op.kind = k;
		op.code = c;
		op.is_last = l;
		op.idx = i;
		op.data = d;
		char_plan.push_back(op);
	endtask

	task automatic plan_cfg(input logic [CFG_INDEX_W-1:0] i, input logic [CFG_DATA_W-1:0] d);
		plan(OP_CFG, '0, 1'b0, i, d);
	endtask

	task automatic plan_text(input string s);
		for (int k = 0; k < s.len(); k++)
			plan(OP_CHAR, s[k], k == s.len() - 1, '0, '0);
	endtask

	function automatic logic [CHAR_W-1:0] pick_digit(input logic hex);
		int r;
		if (!hex)
			return CH_0 + 8'($urandom_range(0, 9));
		r = $urandom_range(0, 40);
		if (r < 10)
			return CH_0 + 8'(r);
		if (r < 23)
			return CH_UPPER_A + 8'($urandom_range(0, 25));
		if (r < 36)
			return CH_LOWER_A + 8'($urandom_range(0, 25));
		return 8'($urandom_range(CH_9 + 1, CH_LOWER_Z));
	endfunction

	task automatic plan_random_string(input logic hexdef, output int n);
		logic [CHAR_W-1:0] s[$];
		int ndig;
		logic hex;
		if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(1, 8))
				s.push_back(8'($urandom_range(0, 255)));
		end else begin
			if ($urandom_range(0, 2) == 0)
				s.push_back(CH_MINUS);
			hex = hexdef;
			case ($urandom_range(0, 3))
			0: begin
				s.push_back(CH_0);
				s.push_back(CH_LOWER_X);
				hex = 1'b1;
			end
			1: begin
				s.push_back($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A);
				hex = 1'b1;
			end
			2: s.push_back(CH_0);
			default: ;
			endcase
			ndig = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
			repeat (ndig)
				s.push_back(pick_digit(hex));
			if ($urandom_range(0, 3) == 0) begin
				s.push_back(8'($urandom_range(0, 255)));
				repeat ($urandom_range(0, 2))
					s.push_back(pick_digit(hex));
			end
		end
		if (s.size() == 0)
			s.push_back(CH_0);
		foreach (s[k])
			plan(OP_CHAR, s[k], k == s.size() - 1, '0, '0);
		n = s.size();
	endtask

	// Driver: presents planned characters and register writes.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
			cfg_wr_en <= 1'b0;
			cfg_index <= '0;
			cfg_data <= '0;
			gap_left = 0;
			quiet = 0;
		end else begin
			nxt_valid = s_tvalid;
			nxt_data = s_tdata;
			nxt_last = s_tlast;
			nxt_wr = 1'b0;
			nxt_index = cfg_index;
			nxt_cfg = cfg_data;
			if (s_tvalid && s_tready) begin
				nxt_valid = 1'b0;
				chars_sent++;
			end
			if (s_tvalid || due_values.size() != 0)
				quiet = 0;
			else if (quiet < DRAIN_CYCLES)
				quiet++;
			calm = char_plan.size() < TAIL_OPS;
			if (idle_span == 0) begin
				idle_span = $urandom_range(50, 300);
				idle_on = $urandom_range(0, 3) != 0;
			end else begin
				idle_span--;
			end
			if (!nxt_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (char_plan.size() != 0) begin
					case (char_plan[0].kind)
					OP_CHAR: begin
						if (idle_on && !calm && $urandom_range(0, 5) == 0) begin
							gap_left = $urandom_range(0, 8);
						end else begin
							nxt_valid = 1'b1;
							nxt_data = char_plan[0].code;
							nxt_last = char_plan[0].is_last;
							void'(char_plan.pop_front());
						end
					end
					OP_CFG: begin
						// Registers change only once the pipeline has drained.
						if (quiet >= DRAIN_CYCLES) begin
							nxt_wr = 1'b1;
							nxt_index = char_plan[0].idx;
							nxt_cfg = char_plan[0].data;
							cfg_writes++;
							quiet = 0;
							void'(char_plan.pop_front());
						end
					end
					default: begin
						if (due_values.size() == 0 && !s_tvalid)
							void'(char_plan.pop_front());
					end
					endcase
				end
			end
			s_tvalid <= nxt_valid;
			s_tdata <= nxt_data;
			s_tlast <= nxt_last;
			cfg_wr_en <= nxt_wr;
			cfg_index <= nxt_index;
			cfg_data <= nxt_cfg;
		end
	end

	// Monitor: tracks register writes, predicts on input transactions and
	// checks output transactions.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left = 0;
			cap = '0;
			min_lim = '0;
			hexdef_r = 1'b0;
			clear_parser();
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
				REG_MAX_VALUE: cap = cfg_data[MAX_W-1:0];
				REG_MIN_VALUE: min_lim = cfg_data[MIN_W-1:0];
				REG_HEX_DEFAULT: hexdef_r = cfg_data[0];
				default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				step_parser(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				if (due_values.size() == 0) begin
					errors++;
					$error("parsed_value: expected none, got %0d", $signed(m_tdata));
				end else begin
					values_checked++;
					if (m_tdata !== due_values[0]) begin
						errors++;
						$error("parsed_value: expected %0d, got %0d",
							$signed(due_values[0]), $signed(m_tdata));
					end
					void'(due_values.pop_front());
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				nxt_ready = 1'b0;
			end else if (idle_on && !calm && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 8);
				nxt_ready = 1'b0;
			end else begin
				nxt_ready = 1'b1;
			end
			m_tready <= nxt_ready;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_text_integer_parser_saturating: done, errors");
			$finish;
		end
	end

	initial begin
		logic [MAX_W-1:0] mx;
		logic [MIN_W-1:0] mn;
		logic hd;
		int phase_chars;
		int n;
		logic held;

		plan_cfg(REG_MAX_VALUE, '0);
		plan_cfg(REG_MIN_VALUE, 32'h8000_0000);
		plan_cfg(REG_HEX_DEFAULT, '0);
		plan_text("-42");
		plan_text("0x1F");
		plan_text("aZ");
		plan_text("-");
		plan_text("0x");
		plan_text("07");
		plan(OP_CHAR, CH_0 + 8'd5, 1'b0, '0, '0);
		plan(OP_CHAR, 8'h00, 1'b1, '0, '0);
		plan(OP_CHAR, 8'hFF, 1'b1, '0, '0);
		// The base is chosen after the sign, so hex_default changes in between.
		plan(OP_CHAR, CH_MINUS, 1'b0, '0, '0);
		plan_cfg(REG_HEX_DEFAULT, 32'd1);
		plan_text("ff");
		plan_cfg(REG_HEX_DEFAULT, '0);
		plan_cfg(REG_MAX_VALUE, 32'd100);
		plan_text("999");
		plan_cfg(REG_MIN_VALUE, 32'd7);
		plan_text("-3");

		for (int p = 0; p < 8; p++) begin
			case (p)
			0: begin
				mx = '0;
				mn = 32'h8000_0000;
				hd = 1'b0;
			end
			1: begin
				mx = '1;
				mn = '0;
				hd = 1'b1;
			end
			2: begin
				mx = 31'($urandom_range(1, 999));
				mn = -32'($urandom_range(1, 1000));
				hd = 1'($urandom_range(0, 1));
			end
			3: begin
				mx = '0;
				mn = 32'h7FFF_FFFF;
				hd = 1'b0;
			end
			4: begin
				mx = 31'd1;
				mn = $urandom;
				hd = 1'b1;
			end
			5: begin
				mx = 31'($urandom);
				mn = 32'($urandom_range(0, 200)) - 32'd100;
				hd = 1'($urandom_range(0, 1));
			end
			default: begin
				mx = 31'($urandom);
				mn = $urandom;
				hd = 1'($urandom_range(0, 1));
			end
			endcase
			plan_cfg(REG_MAX_VALUE, {1'($urandom_range(0, 1)), mx});
			plan_cfg(REG_MIN_VALUE, mn);
			plan_cfg(REG_HEX_DEFAULT, {31'($urandom), hd});
			if (p == 6)
				plan_cfg(REG_UNUSED, $urandom);
			phase_chars = 0;
			held = 1'b0;
			while (phase_chars < PHASE_CHARS) begin
				plan_random_string(hd, n);
				phase_chars += n;
				if ((p == 2 || p == 5) && phase_chars >= PHASE_CHARS / 2 && !held) begin
					plan(OP_HOLD, '0, 1'b0, '0, '0);
					held = 1'b1;
				end
			end
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		while (char_plan.size() != 0 || s_tvalid)
			@(posedge clk);
		while (due_values.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d characters and %0d register writes over eight settings,",
			chars_sent, cfg_writes);
		$display("with %0d parsed values compared and %0d mismatches.", values_checked, errors);
		if (errors == 0)
			$display("tb_text_integer_parser_saturating: done, clean");
		else
			$display("tb_text_integer_parser_saturating: done, errors");
		$finish;
	end

endmodule
